/* hw/rtl/c6502_pkg.sv */
// Shared types, codes and decode table for the 6502 subset core.
`default_nettype none
package c6502_pkg;

  localparam logic [15:0] VecReset  = 16'hFFFC;
  localparam logic [15:0] VecNmi    = 16'hFFFA;
  localparam logic [7:0]  StackPage = 8'h01;
  localparam logic [7:0]  SpReset   = 8'hFD;

  localparam int unsigned FlC = 0;
  localparam int unsigned FlZ = 1;
  localparam int unsigned FlI = 2;
  localparam int unsigned FlD = 3;
  localparam int unsigned FlV = 6;
  localparam int unsigned FlN = 7;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_NMI   = 2'd1,
    OP_RESET = 2'd2,
    OP_ALT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_VECTOR, PH_FETCH, PH_EXEC, PH_NMI, PH_HALT
  } phase_e;

  typedef enum logic [4:0] {
    AM_NONE, AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ABS, AM_ABX, AM_ABY, AM_IZX,
    AM_IZY, AM_REL, AM_JMP, AM_JMPI, AM_JSR, AM_RTS, AM_RTI, AM_PHA, AM_PLA
  } amode_e;

  typedef enum logic [1:0] {
    CL_READ, CL_WRITE, CL_RMW
  } acls_e;

  typedef struct packed {
    amode_e am;
    acls_e  cls;
  } dec_t;

  // Architectural and sequencing state of the core
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic [7:0]  opc;
    logic [15:0] alat;
    logic [7:0]  dlat;
    logic [2:0]  step;
    logic        nmi;
    logic        halt;
    phase_e      phase;
  } cpu_t;

  // One bus access
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        wr;
    logic        fetch;
  } bus_t;

  function automatic dec_t decode(input logic [7:0] o);
    dec_t d;
    d.cls = CL_READ;
    d.am  = AM_NONE;
    case (o)
      8'h0a, 8'h18, 8'h2a, 8'h38, 8'h4a, 8'h78, 8'h88, 8'h8a, 8'h98, 8'h9a,
      8'ha8, 8'haa, 8'hc8, 8'hca, 8'hd8, 8'he8, 8'hf8: d.am = AM_IMP;
      8'h09, 8'h29, 8'h69, 8'h82, 8'ha0, 8'ha2, 8'ha9, 8'hc0, 8'hc9, 8'he0,
      8'he9: d.am = AM_IMM;
      8'h05, 8'h24, 8'h25, 8'h45, 8'h65, 8'ha4, 8'ha5, 8'ha6, 8'hc5,
      8'he4: d.am = AM_ZP;
      8'h84, 8'h85, 8'h86: begin d.am = AM_ZP; d.cls = CL_WRITE; end
      8'h06, 8'h46, 8'h66, 8'hc6, 8'he6: begin d.am = AM_ZP; d.cls = CL_RMW; end
      8'hb5: d.am = AM_ZPX;
      8'h95: begin d.am = AM_ZPX; d.cls = CL_WRITE; end
      8'h17: begin d.am = AM_ZPX; d.cls = CL_RMW; end
      8'h2c, 8'h6d, 8'hac, 8'had, 8'hae, 8'hcd: d.am = AM_ABS;
      8'h8c, 8'h8d, 8'h8e, 8'h8f: begin d.am = AM_ABS; d.cls = CL_WRITE; end
      8'hce, 8'hee: begin d.am = AM_ABS; d.cls = CL_RMW; end
      8'h3d, 8'hbc, 8'hbd: d.am = AM_ABX;
      8'h9d: begin d.am = AM_ABX; d.cls = CL_WRITE; end
      8'h7e, 8'hde: begin d.am = AM_ABX; d.cls = CL_RMW; end
      8'h79, 8'hb9, 8'hbe, 8'hd9, 8'hf9: d.am = AM_ABY;
      8'h99: begin d.am = AM_ABY; d.cls = CL_WRITE; end
      8'ha1: d.am = AM_IZX;
      8'hb1: d.am = AM_IZY;
      8'h91: begin d.am = AM_IZY; d.cls = CL_WRITE; end
      8'h10, 8'h30, 8'h90, 8'hb0, 8'hd0, 8'hf0: d.am = AM_REL;
      8'h4c: d.am = AM_JMP;
      8'h6c: d.am = AM_JMPI;
      8'h20: d.am = AM_JSR;
      8'h60: d.am = AM_RTS;
      8'h40: d.am = AM_RTI;
      8'h48: d.am = AM_PHA;
      8'h68: d.am = AM_PLA;
      default: d.am = AM_NONE;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] addr_steps(input amode_e am);
    logic [2:0] n;
    case (am)
      AM_ZP, AM_ZPX: n = 3'd1;
      AM_ABS, AM_ABX, AM_ABY: n = 3'd2;
      AM_IZX, AM_IZY: n = 3'd3;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic cpu_t reset_state();
    cpu_t s;
    s = '0;
    s.sp = SpReset;
    s.p = 8'h04;
    s.alat = VecReset;
    s.phase = PH_VECTOR;
    return s;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/c6502_alu.sv */
// Data-path operations: read ops, read-modify-write ops and implied ops.
`default_nettype none
module c6502_alu (
  input  var c6502_pkg::cpu_t s_i,
  input  wire logic [7:0]     v_i,
  output var c6502_pkg::cpu_t rd_o,
  output var c6502_pkg::cpu_t rmw_o,
  output logic [7:0]          rmw_val_o,
  output var c6502_pkg::cpu_t imp_o
);
  import c6502_pkg::*;

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FlZ] = (v == 8'h00);
    r[FlN] = v[7];
    return r;
  endfunction

  logic [8:0] sum;
  logic [7:0] addend;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;

  always_comb begin
    addend = (s_i.opc == 8'he9 || s_i.opc == 8'hf9) ? ~v_i : v_i;
    sum = {1'b0, s_i.a} + {1'b0, addend} + {8'h00, s_i.p[FlC]};
    case (s_i.opc)
      8'he0, 8'he4: cmp_reg = s_i.x;
      8'hc0: cmp_reg = s_i.y;
      default: cmp_reg = s_i.a;
    endcase
    cmp_diff = {1'b0, cmp_reg} - {1'b0, v_i};
  end

  always_comb begin
    rd_o = s_i;
    case (s_i.opc)
      8'h05, 8'h09: begin rd_o.a = s_i.a | v_i; rd_o.p = nz(s_i.p, s_i.a | v_i); end
      8'h25, 8'h29, 8'h3d: begin
        rd_o.a = s_i.a & v_i; rd_o.p = nz(s_i.p, s_i.a & v_i);
      end
      8'h45: begin rd_o.a = s_i.a ^ v_i; rd_o.p = nz(s_i.p, s_i.a ^ v_i); end
      8'h65, 8'h69, 8'h6d, 8'h79, 8'he9, 8'hf9: begin
        rd_o.a = sum[7:0];
        rd_o.p = nz(s_i.p, sum[7:0]);
        rd_o.p[FlC] = sum[8];
        rd_o.p[FlV] = ~(s_i.a[7] ^ addend[7]) & (s_i.a[7] ^ sum[7]);
      end
      8'hc5, 8'hc9, 8'hcd, 8'hd9, 8'he0, 8'he4, 8'hc0: begin
        rd_o.p[FlC] = ~cmp_diff[8];
        rd_o.p[FlZ] = (cmp_reg == v_i);
        rd_o.p[FlN] = cmp_diff[7];
      end
      8'h24, 8'h2c: begin
        rd_o.p[FlZ] = ((s_i.a & v_i) == 8'h00);
        rd_o.p[FlN] = v_i[7];
        rd_o.p[FlV] = v_i[6];
      end
      8'ha0, 8'ha4, 8'hac, 8'hbc: begin rd_o.y = v_i; rd_o.p = nz(s_i.p, v_i); end
      8'ha2, 8'ha6, 8'hae, 8'hbe: begin rd_o.x = v_i; rd_o.p = nz(s_i.p, v_i); end
      8'h82: rd_o = s_i;
      default: begin rd_o.a = v_i; rd_o.p = nz(s_i.p, v_i); end
    endcase
  end

  logic [7:0] shl_v;
  always_comb begin
    rmw_o = s_i;
    shl_v = {v_i[6:0], 1'b0};
    case (s_i.opc)
      8'h06: begin
        rmw_val_o = shl_v; rmw_o.p = nz(s_i.p, shl_v); rmw_o.p[FlC] = v_i[7];
      end
      8'h46: begin
        rmw_val_o = {1'b0, v_i[7:1]};
        rmw_o.p = nz(s_i.p, {1'b0, v_i[7:1]}); rmw_o.p[FlC] = v_i[0];
      end
      8'h66, 8'h7e: begin
        rmw_val_o = {s_i.p[FlC], v_i[7:1]};
        rmw_o.p = nz(s_i.p, {s_i.p[FlC], v_i[7:1]}); rmw_o.p[FlC] = v_i[0];
      end
      8'hc6, 8'hce, 8'hde: begin
        rmw_val_o = v_i - 8'd1; rmw_o.p = nz(s_i.p, v_i - 8'd1);
      end
      8'he6, 8'hee: begin
        rmw_val_o = v_i + 8'd1; rmw_o.p = nz(s_i.p, v_i + 8'd1);
      end
      default: begin
        rmw_val_o = shl_v;
        rmw_o.a = s_i.a | shl_v;
        rmw_o.p = nz(s_i.p, s_i.a | shl_v); rmw_o.p[FlC] = v_i[7];
      end
    endcase
  end

  // Implied ops run as their opcode arrives, so decode them from v_i
  logic [7:0] ashl;
  always_comb begin
    imp_o = s_i;
    ashl = {s_i.a[6:0], 1'b0};
    case (v_i)
      8'h0a: begin imp_o.a = ashl; imp_o.p = nz(s_i.p, ashl); imp_o.p[FlC] = s_i.a[7]; end
      8'h4a: begin
        imp_o.a = {1'b0, s_i.a[7:1]};
        imp_o.p = nz(s_i.p, {1'b0, s_i.a[7:1]}); imp_o.p[FlC] = s_i.a[0];
      end
      8'h2a: begin
        imp_o.a = {s_i.a[6:0], s_i.p[FlC]};
        imp_o.p = nz(s_i.p, {s_i.a[6:0], s_i.p[FlC]}); imp_o.p[FlC] = s_i.a[7];
      end
      8'h18: imp_o.p[FlC] = 1'b0;
      8'h38: imp_o.p[FlC] = 1'b1;
      8'h78: imp_o.p[FlI] = 1'b1;
      8'hd8: imp_o.p[FlD] = 1'b0;
      8'hf8: imp_o.p[FlD] = 1'b1;
      8'h88: begin imp_o.y = s_i.y - 8'd1; imp_o.p = nz(s_i.p, s_i.y - 8'd1); end
      8'hca: begin imp_o.x = s_i.x - 8'd1; imp_o.p = nz(s_i.p, s_i.x - 8'd1); end
      8'hc8: begin imp_o.y = s_i.y + 8'd1; imp_o.p = nz(s_i.p, s_i.y + 8'd1); end
      8'he8: begin imp_o.x = s_i.x + 8'd1; imp_o.p = nz(s_i.p, s_i.x + 8'd1); end
      8'h8a: begin imp_o.a = s_i.x; imp_o.p = nz(s_i.p, s_i.x); end
      8'h98: begin imp_o.a = s_i.y; imp_o.p = nz(s_i.p, s_i.y); end
      8'ha8: begin imp_o.y = s_i.a; imp_o.p = nz(s_i.p, s_i.a); end
      8'haa: begin imp_o.x = s_i.a; imp_o.p = nz(s_i.p, s_i.a); end
      default: imp_o.sp = s_i.x;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/c6502_seq.sv */
// Bus-cycle sequencer: next state and next bus access for one transfer.
`default_nettype none
module c6502_seq (
  input  var c6502_pkg::cpu_t s_i,
  input  var c6502_pkg::bus_t bus_i,
  input  wire logic [1:0]     op_i,
  input  wire logic [7:0]     d_i,
  output var c6502_pkg::cpu_t s_o,
  output var c6502_pkg::bus_t bus_o
);
  import c6502_pkg::*;

  cpu_t       rd_s, rmw_s, imp_s, n;
  logic [7:0] rmw_val;
  dec_t       dc, df;
  logic [2:0] nst;
  logic [15:0] word;
  logic [15:0] ea;
  logic       taken;
  logic [7:0] stv;

  c6502_alu u_alu (
    .s_i      (s_i),
    .v_i      (d_i),
    .rd_o     (rd_s),
    .rmw_o    (rmw_s),
    .rmw_val_o(rmw_val),
    .imp_o    (imp_s)
  );

  function automatic bus_t rdb(input logic [15:0] a);
    bus_t b;
    b.addr = a; b.wdata = 8'h00; b.wr = 1'b0; b.fetch = 1'b0;
    return b;
  endfunction

  function automatic bus_t wrb(input logic [15:0] a, input logic [7:0] v);
    bus_t b;
    b.addr = a; b.wdata = v; b.wr = 1'b1; b.fetch = 1'b0;
    return b;
  endfunction

  // Finish the instruction: take NMI or fetch the next opcode
  task automatic go_fetch(inout cpu_t t, output bus_t b);
    t.step = 3'd0;
    if (t.nmi) begin
      t.nmi = 1'b0;
      t.phase = PH_NMI;
      b = wrb({StackPage, t.sp}, t.pc[15:8]);
      t.sp = t.sp - 8'd1;
    end else begin
      t.phase = PH_FETCH;
      b.addr = t.pc; b.wdata = 8'h00; b.wr = 1'b0; b.fetch = 1'b1;
    end
  endtask

  task automatic access(inout cpu_t t, output bus_t b, input logic [15:0] a,
                        input acls_e c, input logic [7:0] v);
    t.alat = a;
    if (c == CL_WRITE) b = wrb(a, v);
    else b = rdb(a);
  endtask

  always_comb begin
    dc = decode(s_i.opc);
    df = decode(d_i);
    word = {d_i, s_i.dlat};
    case (s_i.opc)
      8'h84, 8'h8c: stv = s_i.y;
      8'h86, 8'h8e: stv = s_i.x;
      8'h8f: stv = s_i.a & s_i.x;
      default: stv = s_i.a;
    endcase
    case (s_i.opc)
      8'h10: taken = ~s_i.p[FlN];
      8'h30: taken = s_i.p[FlN];
      8'h90: taken = ~s_i.p[FlC];
      8'hb0: taken = s_i.p[FlC];
      8'hd0: taken = ~s_i.p[FlZ];
      default: taken = s_i.p[FlZ];
    endcase
    case (dc.am)
      AM_ABX: ea = word + {8'h00, s_i.x};
      AM_ABY, AM_IZY: ea = word + {8'h00, s_i.y};
      default: ea = word;
    endcase
    nst = addr_steps(dc.am);
  end

  always_comb begin
    n = s_i;
    bus_o = bus_i;
    if (op_i == OP_RESET) begin
      n = reset_state();
      bus_o = rdb(VecReset);
    end else if (op_i == OP_NMI) begin
      n.nmi = 1'b1;
    end else if (!s_i.halt) begin
      unique case (s_i.phase)
        PH_VECTOR: begin
          if (s_i.step == 3'd0) begin
            n.dlat = d_i; n.step = 3'd1; bus_o = rdb(s_i.alat + 16'd1);
          end else begin
            n.pc = word; go_fetch(n, bus_o);
          end
        end
        PH_FETCH: begin
          n.opc = d_i;
          n.step = 3'd0;
          if (df.am == AM_NONE) begin
            n.halt = 1'b1; n.phase = PH_HALT; bus_o = rdb(s_i.pc);
          end else begin
            n.pc = s_i.pc + 16'd1;
            n.phase = PH_EXEC;
            case (df.am)
              AM_IMP: begin
                // implied ops complete here, decoded from the arriving opcode
                n = imp_s;
                n.opc = d_i;
                n.pc = s_i.pc + 16'd1;
                n.step = 3'd0;
                bus_o = rdb(16'h0000);
                go_fetch(n, bus_o);
              end
              AM_IMM: begin
                n.alat = s_i.pc + 16'd1;
                bus_o = rdb(s_i.pc + 16'd1);
                n.pc = s_i.pc + 16'd2;
              end
              AM_RTS, AM_RTI, AM_PLA: begin
                n.sp = s_i.sp + 8'd1; bus_o = rdb({StackPage, s_i.sp + 8'd1});
              end
              AM_PHA: begin
                bus_o = wrb({StackPage, s_i.sp}, s_i.a); n.sp = s_i.sp - 8'd1;
              end
              default: begin
                bus_o = rdb(s_i.pc + 16'd1); n.pc = s_i.pc + 16'd2;
              end
            endcase
          end
        end
        PH_EXEC: begin
          n.step = s_i.step + 3'd1;
          case (dc.am)
            AM_IMP: begin
              n = imp_s; go_fetch(n, bus_o);
            end
            AM_REL: begin
              if (taken) n.pc = s_i.pc + {{8{d_i[7]}}, d_i};
              go_fetch(n, bus_o);
            end
            AM_JMP, AM_JMPI: begin
              if (s_i.step == 3'd0) begin
                n.dlat = d_i; bus_o = rdb(s_i.pc); n.pc = s_i.pc + 16'd1;
              end else if (s_i.step == 3'd1 && dc.am == AM_JMP) begin
                n.pc = word; go_fetch(n, bus_o);
              end else if (s_i.step == 3'd1) begin
                n.alat = word; bus_o = rdb(word);
              end else if (s_i.step == 3'd2) begin
                n.dlat = d_i;
                bus_o = rdb({s_i.alat[15:8], s_i.alat[7:0] + 8'd1});
              end else begin
                n.pc = word; go_fetch(n, bus_o);
              end
            end
            AM_JSR: begin
              if (s_i.step == 3'd0) begin
                n.dlat = d_i; bus_o = rdb(s_i.pc);
              end else if (s_i.step == 3'd1) begin
                n.alat = word;
                bus_o = wrb({StackPage, s_i.sp}, s_i.pc[15:8]); n.sp = s_i.sp - 8'd1;
              end else if (s_i.step == 3'd2) begin
                bus_o = wrb({StackPage, s_i.sp}, s_i.pc[7:0]); n.sp = s_i.sp - 8'd1;
              end else begin
                n.pc = s_i.alat; go_fetch(n, bus_o);
              end
            end
            AM_RTS: begin
              if (s_i.step == 3'd0) begin
                n.dlat = d_i; n.sp = s_i.sp + 8'd1;
                bus_o = rdb({StackPage, s_i.sp + 8'd1});
              end else begin
                n.pc = word + 16'd1; go_fetch(n, bus_o);
              end
            end
            AM_RTI: begin
              if (s_i.step == 3'd0) begin
                n.p = d_i & 8'hCF; n.sp = s_i.sp + 8'd1;
                bus_o = rdb({StackPage, s_i.sp + 8'd1});
              end else if (s_i.step == 3'd1) begin
                n.dlat = d_i; n.sp = s_i.sp + 8'd1;
                bus_o = rdb({StackPage, s_i.sp + 8'd1});
              end else begin
                n.pc = word; go_fetch(n, bus_o);
              end
            end
            AM_PHA: go_fetch(n, bus_o);
            AM_PLA: begin
              n.a = d_i; n.p[FlZ] = (d_i == 8'h00); n.p[FlN] = d_i[7];
              go_fetch(n, bus_o);
            end
            default: begin
              if (s_i.step >= nst) begin
                if (s_i.step == nst && dc.cls == CL_READ) begin
                  n = rd_s; n.step = s_i.step + 3'd1; go_fetch(n, bus_o);
                end else if (s_i.step == nst && dc.cls == CL_RMW) begin
                  n = rmw_s; n.step = s_i.step + 3'd1;
                  bus_o = wrb(s_i.alat, rmw_val);
                end else begin
                  go_fetch(n, bus_o);
                end
              end else begin
                case (dc.am)
                  AM_ZP: access(n, bus_o, {8'h00, d_i}, dc.cls, stv);
                  AM_ZPX: access(n, bus_o, {8'h00, d_i + s_i.x}, dc.cls, stv);
                  AM_ABS, AM_ABX, AM_ABY: begin
                    if (s_i.step == 3'd0) begin
                      n.dlat = d_i; bus_o = rdb(s_i.pc); n.pc = s_i.pc + 16'd1;
                    end else begin
                      access(n, bus_o, ea, dc.cls, stv);
                    end
                  end
                  default: begin
                    if (s_i.step == 3'd0) begin
                      n.alat = {8'h00, d_i + ((dc.am == AM_IZX) ? s_i.x : 8'h00)};
                      bus_o = rdb({8'h00, d_i + ((dc.am == AM_IZX) ? s_i.x : 8'h00)});
                    end else if (s_i.step == 3'd1) begin
                      n.dlat = d_i; bus_o = rdb({8'h00, s_i.alat[7:0] + 8'd1});
                    end else begin
                      access(n, bus_o, ea, dc.cls, stv);
                    end
                  end
                endcase
              end
            end
          endcase
        end
        PH_NMI: begin
          n.step = s_i.step + 3'd1;
          if (s_i.step == 3'd0) begin
            bus_o = wrb({StackPage, s_i.sp}, s_i.pc[7:0]); n.sp = s_i.sp - 8'd1;
          end else if (s_i.step == 3'd1) begin
            bus_o = wrb({StackPage, s_i.sp}, s_i.p | 8'h20); n.sp = s_i.sp - 8'd1;
          end else begin
            n.p[FlI] = 1'b1;
            n.phase = PH_VECTOR; n.step = 3'd0; n.alat = VecNmi;
            bus_o = rdb(VecNmi);
          end
        end
        PH_HALT: n = s_i;
        default: n = s_i;
      endcase
    end
    s_o = n;
  end

endmodule
`default_nettype wire

/* hw/rtl/cpu_6502_subset_core.sv */
// A transfer in is answered by its bus access in the next cycle.
// Throughput: one transfer per cycle while out_ready_i is high; the whole
// bus step runs in one sequencer pass between state and result registers.
// Reset: rst_ni clears the core to its reset state with the pending access
// a read of the reset vector; no result is shown until the first transfer.
`default_nettype none
module cpu_6502_subset_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  read_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      bus_address_o,
  output logic [7:0]       write_data_o,
  output logic             bus_write_o,
  output logic             opcode_fetch_o,
  output logic             halted_o,
  output logic [7:0]       status_flags_o
);
  import c6502_pkg::*;

  cpu_t state_q, state_d;
  bus_t bus_q, bus_d;
  logic valid_q;
  logic fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire = in_valid_i && in_ready_o;

  c6502_seq u_seq (
    .s_i  (state_q),
    .bus_i(bus_q),
    .op_i (op_i),
    .d_i  (read_data_i),
    .s_o  (state_d),
    .bus_o(bus_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
      bus_q   <= '{addr: VecReset, wdata: 8'h00, wr: 1'b0, fetch: 1'b0};
      valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
        bus_q   <= bus_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign bus_address_o  = bus_q.addr;
  assign write_data_o   = bus_q.wdata;
  assign bus_write_o    = bus_q.wr;
  assign opcode_fetch_o = bus_q.fetch;
  assign halted_o       = state_q.halt;
  assign status_flags_o = state_q.p;

`ifndef SYNTHESIS
  a_wr_not_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bus_q.wr && bus_q.fetch)) else $error("write access marked as fetch");
  a_halt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.halt && !(fire && op_i == OP_RESET)) |=> state_q.halt)
    else $error("halt left without reset");
  a_flags_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.p[5:4] == 2'b00) else $error("flag bits 5:4 set");
`endif

endmodule
`default_nettype wire

/* tb/tb_cpu_6502_subset_core.sv */
// Self-checking testbench for cpu_6502_subset_core: a table of directed steps, then random programs.
module tb_cpu_6502_subset_core;
  import c6502_pkg::*;

  localparam int NumRandom = 450;
  localparam int WatchLimit = 3000;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        wr;
    logic        fetch;
    logic        halt;
    logic [7:0]  flags;
  } access_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    bit         typed;
    access_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [1:0]  op_i = OP_DATA;
  logic [7:0]  read_data_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o, out_valid_o, bus_write_o, opcode_fetch_o, halted_o;
  logic [15:0] bus_address_o;
  logic [7:0]  write_data_o, status_flags_o;

  cpu_6502_subset_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .read_data_i,
    .out_valid_o, .out_ready_i, .bus_address_o, .write_data_o, .bus_write_o,
    .opcode_fetch_o, .halted_o, .status_flags_o
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the core
  logic [7:0]  r_a, r_x, r_y, r_sp, r_p, r_opc, r_dlat;
  logic [15:0] r_pc, r_alat;
  logic [2:0]  r_step;
  logic        r_nmi, r_halt;
  phase_e      r_phase;
  logic [15:0] b_addr;
  logic [7:0]  b_data;
  logic        b_wr, b_fetch;

  access_t     pending_accesses[$];
  row_t        rows[$];
  int          errors = 0, sent = 0, got = 0, n_halts = 0, n_nmis = 0, n_resets = 0;
  int          idle_cycles = 0;
  bit          stim_done = 0;

  logic [7:0] opcode_pool[$] = '{
    8'h0a, 8'h18, 8'h2a, 8'h38, 8'h4a, 8'h78, 8'h88, 8'h8a, 8'h98, 8'h9a, 8'ha8, 8'haa,
    8'hc8, 8'hca, 8'hd8, 8'he8, 8'hf8, 8'h09, 8'h29, 8'h69, 8'h82, 8'ha0, 8'ha2, 8'ha9,
    8'hc0, 8'hc9, 8'he0, 8'he9, 8'h05, 8'h24, 8'h25, 8'h45, 8'h65, 8'ha4, 8'ha5, 8'ha6,
    8'hc5, 8'he4, 8'h84, 8'h85, 8'h86, 8'h06, 8'h46, 8'h66, 8'hc6, 8'he6, 8'hb5, 8'h95,
    8'h17, 8'h2c, 8'h6d, 8'hac, 8'had, 8'hae, 8'hcd, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'hce,
    8'hee, 8'h3d, 8'hbc, 8'hbd, 8'h9d, 8'h7e, 8'hde, 8'h79, 8'hb9, 8'hbe, 8'hd9, 8'hf9,
    8'h99, 8'ha1, 8'hb1, 8'h91, 8'h10, 8'h30, 8'h90, 8'hb0, 8'hd0, 8'hf0, 8'h4c, 8'h6c,
    8'h20, 8'h60, 8'h40, 8'h48, 8'h68};

  function automatic void classify(input logic [7:0] o, output amode_e am, output acls_e cl);
    cl = CL_READ;
    case (o)
      8'h0a, 8'h18, 8'h2a, 8'h38, 8'h4a, 8'h78, 8'h88, 8'h8a, 8'h98, 8'h9a, 8'ha8, 8'haa,
      8'hc8, 8'hca, 8'hd8, 8'he8, 8'hf8: am = AM_IMP;
      8'h09, 8'h29, 8'h69, 8'h82, 8'ha0, 8'ha2, 8'ha9, 8'hc0, 8'hc9, 8'he0, 8'he9:
        am = AM_IMM;
      8'h05, 8'h24, 8'h25, 8'h45, 8'h65, 8'ha4, 8'ha5, 8'ha6, 8'hc5, 8'he4: am = AM_ZP;
      8'h84, 8'h85, 8'h86: begin am = AM_ZP; cl = CL_WRITE; end
      8'h06, 8'h46, 8'h66, 8'hc6, 8'he6: begin am = AM_ZP; cl = CL_RMW; end
      8'hb5: am = AM_ZPX;
      8'h95: begin am = AM_ZPX; cl = CL_WRITE; end
      8'h17: begin am = AM_ZPX; cl = CL_RMW; end
      8'h2c, 8'h6d, 8'hac, 8'had, 8'hae, 8'hcd: am = AM_ABS;
      8'h8c, 8'h8d, 8'h8e, 8'h8f: begin am = AM_ABS; cl = CL_WRITE; end
      8'hce, 8'hee: begin am = AM_ABS; cl = CL_RMW; end
      8'h3d, 8'hbc, 8'hbd: am = AM_ABX;
      8'h9d: begin am = AM_ABX; cl = CL_WRITE; end
      8'h7e, 8'hde: begin am = AM_ABX; cl = CL_RMW; end
      8'h79, 8'hb9, 8'hbe, 8'hd9, 8'hf9: am = AM_ABY;
      8'h99: begin am = AM_ABY; cl = CL_WRITE; end
      8'ha1: am = AM_IZX;
      8'hb1: am = AM_IZY;
      8'h91: begin am = AM_IZY; cl = CL_WRITE; end
      8'h10, 8'h30, 8'h90, 8'hb0, 8'hd0, 8'hf0: am = AM_REL;
      8'h4c: am = AM_JMP;
      8'h6c: am = AM_JMPI;
      8'h20: am = AM_JSR;
      8'h60: am = AM_RTS;
      8'h40: am = AM_RTI;
      8'h48: am = AM_PHA;
      8'h68: am = AM_PLA;
      default: am = AM_NONE;
    endcase
  endfunction

  task automatic issue(input logic [15:0] a, input logic [7:0] w, input logic wr, input logic f);
    b_addr = a; b_data = w; b_wr = wr; b_fetch = f;
  endtask

  task automatic rd(input logic [15:0] a);
    issue(a, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic set_nz(input logic [7:0] v);
    r_p[FlZ] = (v == 8'h00);
    r_p[FlN] = v[7];
  endtask

  task automatic push(input logic [7:0] v);
    issue({StackPage, r_sp}, v, 1'b1, 1'b0);
    r_sp = r_sp - 8'd1;
  endtask

  task automatic pull_read();
    r_sp = r_sp + 8'd1;
    rd({StackPage, r_sp});
  endtask

  task automatic start_vector(input logic [15:0] v);
    r_phase = PH_VECTOR; r_step = 0; r_alat = v; rd(v);
  endtask

  task automatic next_fetch();
    r_step = 0;
    if (r_nmi) begin
      r_nmi = 0;
      r_phase = PH_NMI;
      push(r_pc[15:8]);
    end else begin
      r_phase = PH_FETCH;
      issue(r_pc, 8'h00, 1'b0, 1'b1);
    end
  endtask

  task automatic core_reset();
    r_a = 0; r_x = 0; r_y = 0; r_sp = SpReset; r_p = 8'h04; r_pc = 0; r_opc = 0;
    r_dlat = 0; r_nmi = 0; r_halt = 0;
    start_vector(VecReset);
  endtask

  task automatic add_carry(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, r_a} + {1'b0, v} + {8'h00, r_p[FlC]};
    r_p[FlC] = sum[8];
    r_p[FlV] = ~(r_a[7] ^ v[7]) & (r_a[7] ^ sum[7]);
    r_a = sum[7:0];
    set_nz(r_a);
  endtask

  task automatic cmp(input logic [7:0] r, input logic [7:0] v);
    logic [7:0] d;
    d = r - v;
    r_p[FlC] = (r >= v);
    r_p[FlZ] = (r == v);
    r_p[FlN] = d[7];
  endtask

  task automatic asl_byte(inout logic [7:0] v);
    r_p[FlC] = v[7];
    v = {v[6:0], 1'b0};
    set_nz(v);
  endtask

  task automatic lsr_byte(inout logic [7:0] v);
    r_p[FlC] = v[0];
    v = {1'b0, v[7:1]};
    set_nz(v);
  endtask

  task automatic read_op(input logic [7:0] o, input logic [7:0] v);
    case (o)
      8'h05, 8'h09: begin r_a = r_a | v; set_nz(r_a); end
      8'h25, 8'h29, 8'h3d: begin r_a = r_a & v; set_nz(r_a); end
      8'h45: begin r_a = r_a ^ v; set_nz(r_a); end
      8'h65, 8'h69, 8'h6d, 8'h79: add_carry(v);
      8'he9, 8'hf9: add_carry(~v);
      8'hc5, 8'hc9, 8'hcd, 8'hd9: cmp(r_a, v);
      8'he0, 8'he4: cmp(r_x, v);
      8'hc0: cmp(r_y, v);
      8'h24, 8'h2c: begin
        r_p[FlZ] = ((r_a & v) == 8'h00);
        r_p[FlN] = v[7];
        r_p[FlV] = v[6];
      end
      8'ha0, 8'ha4, 8'hac, 8'hbc: begin r_y = v; set_nz(v); end
      8'ha2, 8'ha6, 8'hae, 8'hbe: begin r_x = v; set_nz(v); end
      8'h82: ;
      default: begin r_a = v; set_nz(v); end
    endcase
  endtask

  task automatic modify_op(input logic [7:0] o, inout logic [7:0] v);
    logic c;
    case (o)
      8'h06: asl_byte(v);
      8'h46: lsr_byte(v);
      8'h66, 8'h7e: begin
        c = r_p[FlC];
        lsr_byte(v);
        v[7] = c;
        set_nz(v);
      end
      8'hc6, 8'hce, 8'hde: begin v = v - 8'd1; set_nz(v); end
      8'he6, 8'hee: begin v = v + 8'd1; set_nz(v); end
      default: begin
        asl_byte(v);
        r_a = r_a | v;
        set_nz(r_a);
      end
    endcase
  endtask

  function automatic logic [7:0] store_byte(input logic [7:0] o);
    case (o)
      8'h84, 8'h8c: return r_y;
      8'h86, 8'h8e: return r_x;
      8'h8f: return r_a & r_x;
      default: return r_a;
    endcase
  endfunction

  task automatic implied_op(input logic [7:0] o);
    logic c;
    case (o)
      8'h0a: asl_byte(r_a);
      8'h4a: lsr_byte(r_a);
      8'h2a: begin
        c = r_p[FlC];
        asl_byte(r_a);
        r_a[0] = c;
        set_nz(r_a);
      end
      8'h18: r_p[FlC] = 1'b0;
      8'h38: r_p[FlC] = 1'b1;
      8'h78: r_p[FlI] = 1'b1;
      8'hd8: r_p[FlD] = 1'b0;
      8'hf8: r_p[FlD] = 1'b1;
      8'h88: begin r_y = r_y - 8'd1; set_nz(r_y); end
      8'hca: begin r_x = r_x - 8'd1; set_nz(r_x); end
      8'hc8: begin r_y = r_y + 8'd1; set_nz(r_y); end
      8'he8: begin r_x = r_x + 8'd1; set_nz(r_x); end
      8'h8a: begin r_a = r_x; set_nz(r_a); end
      8'h98: begin r_a = r_y; set_nz(r_a); end
      8'ha8: begin r_y = r_a; set_nz(r_y); end
      8'haa: begin r_x = r_a; set_nz(r_x); end
      default: r_sp = r_x;
    endcase
  endtask

  function automatic bit branch_on(input logic [7:0] o);
    case (o)
      8'h10: return !r_p[FlN];
      8'h30: return r_p[FlN];
      8'h90: return !r_p[FlC];
      8'hb0: return r_p[FlC];
      8'hd0: return !r_p[FlZ];
      default: return r_p[FlZ];
    endcase
  endfunction

  task automatic access_ea(input logic [15:0] ea, input acls_e cl);
    r_alat = ea;
    if (cl == CL_WRITE) issue(r_alat, store_byte(r_opc), 1'b1, 1'b0);
    else rd(r_alat);
  endtask

  task automatic read_operand();
    rd(r_pc);
    r_pc = r_pc + 16'd1;
  endtask

  function automatic logic [2:0] ea_steps(input amode_e am);
    case (am)
      AM_ZP, AM_ZPX: return 3'd1;
      AM_ABS, AM_ABX, AM_ABY: return 3'd2;
      AM_IZX, AM_IZY: return 3'd3;
      default: return 3'd0;
    endcase
  endfunction

  task automatic execute_data(input logic [7:0] d);
    amode_e      am;
    acls_e       cl;
    logic [2:0]  s, n;
    logic [15:0] word;
    logic [7:0]  v;
    classify(r_opc, am, cl);
    s = r_step;
    n = ea_steps(am);
    word = {d, r_dlat};
    r_step = s + 3'd1;
    case (am)
      AM_REL: begin
        if (branch_on(r_opc)) r_pc = r_pc + {{8{d[7]}}, d};
        next_fetch();
      end
      AM_JMP, AM_JMPI: begin
        if (s == 0) begin r_dlat = d; read_operand(); end
        else if (s == 1 && am == AM_JMP) begin r_pc = word; next_fetch(); end
        else if (s == 1) begin r_alat = word; rd(r_alat); end
        else if (s == 2) begin r_dlat = d; rd({r_alat[15:8], r_alat[7:0] + 8'd1}); end
        else begin r_pc = word; next_fetch(); end
      end
      AM_JSR: begin
        if (s == 0) begin r_dlat = d; rd(r_pc); end
        else if (s == 1) begin r_alat = word; push(r_pc[15:8]); end
        else if (s == 2) push(r_pc[7:0]);
        else begin r_pc = r_alat; next_fetch(); end
      end
      AM_RTS: begin
        if (s == 0) begin r_dlat = d; pull_read(); end
        else begin r_pc = word + 16'd1; next_fetch(); end
      end
      AM_RTI: begin
        if (s == 0) begin r_p = d & 8'hCF; pull_read(); end
        else if (s == 1) begin r_dlat = d; pull_read(); end
        else begin r_pc = word; next_fetch(); end
      end
      AM_PHA: next_fetch();
      AM_PLA: begin r_a = d; set_nz(d); next_fetch(); end
      default: begin
        if (s >= n) begin
          if (s == n && cl == CL_READ) begin read_op(r_opc, d); next_fetch(); end
          else if (s == n && cl == CL_RMW) begin
            v = d;
            modify_op(r_opc, v);
            issue(r_alat, v, 1'b1, 1'b0);
          end else next_fetch();
        end else begin
          case (am)
            AM_ZP: access_ea({8'h00, d}, cl);
            AM_ZPX: access_ea({8'h00, d + r_x}, cl);
            AM_ABS, AM_ABX, AM_ABY: begin
              if (s == 0) begin r_dlat = d; read_operand(); end
              else access_ea(word + (am == AM_ABX ? {8'h00, r_x} :
                                     am == AM_ABY ? {8'h00, r_y} : 16'h0000), cl);
            end
            default: begin
              if (s == 0) begin
                r_alat = {8'h00, d + (am == AM_IZX ? r_x : 8'h00)};
                rd(r_alat);
              end else if (s == 1) begin
                r_dlat = d;
                rd({8'h00, r_alat[7:0] + 8'd1});
              end else begin
                access_ea(word + (am == AM_IZY ? {8'h00, r_y} : 16'h0000), cl);
              end
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic bus_cycle(input logic [7:0] d);
    amode_e am;
    acls_e  cl;
    case (r_phase)
      PH_VECTOR: begin
        if (r_step == 0) begin r_dlat = d; r_step = 1; rd(r_alat + 16'd1); end
        else begin r_pc = {d, r_dlat}; next_fetch(); end
      end
      PH_FETCH: begin
        classify(d, am, cl);
        r_opc = d;
        if (am == AM_NONE) begin
          r_halt = 1; r_phase = PH_HALT; r_step = 0; n_halts++;
          rd(r_pc);
        end else begin
          r_pc = r_pc + 16'd1;
          r_phase = PH_EXEC; r_step = 0;
          case (am)
            AM_IMP: begin implied_op(r_opc); next_fetch(); end
            AM_IMM: begin access_ea(r_pc, cl); r_pc = r_pc + 16'd1; end
            AM_RTS, AM_RTI, AM_PLA: pull_read();
            AM_PHA: push(r_a);
            default: read_operand();
          endcase
        end
      end
      PH_EXEC: execute_data(d);
      PH_NMI: begin
        r_step = r_step + 3'd1;
        if (r_step == 1) push(r_pc[7:0]);
        else if (r_step == 2) push(r_p | 8'h20);
        else begin r_p[FlI] = 1'b1; start_vector(VecNmi); end
      end
      default: ;
    endcase
  endtask

  task automatic predict_access(input logic [1:0] op, input logic [7:0] d,
                                output access_t acc);
    if (op == OP_RESET) core_reset();
    else if (op == OP_NMI) r_nmi = 1;
    else if (!r_halt) bus_cycle(d);
    acc = {b_addr, b_data, b_wr, b_fetch, r_halt, r_p};
  endtask

  task automatic report(input string what, input access_t seen, input access_t want);
    errors++;
    $display("MISMATCH %s: got addr %h wd %h wr %b f %b h %b p %h, want %h %h %b %b %b %h",
             what, seen.addr, seen.wdata, seen.wr, seen.fetch, seen.halt, seen.flags,
             want.addr, want.wdata, want.wr, want.fetch, want.halt, want.flags);
  endtask

  function automatic row_t mk(input logic [1:0] op, input logic [7:0] d);
    row_t r;
    r.op = op; r.data = d; r.typed = 0; r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_typed(input logic [1:0] op, input logic [7:0] d, input access_t w);
    row_t r;
    r = mk(op, d);
    r.typed = 1; r.want = w;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Next stimulus item, drawn from where the shadow core stands right now
  task automatic pick_item(output logic [1:0] op, output logic [7:0] d);
    int r;
    r = $urandom_range(0, 99);
    d = random_byte();
    if (r_halt) op = ($urandom_range(0, 2) == 0) ? OP_RESET : 2'($urandom_range(0, 3));
    else if (r < 3) op = OP_NMI;
    else if (r < 4) op = OP_RESET;
    else begin
      op = (r < 6) ? OP_ALT : OP_DATA;
      if (b_fetch && $urandom_range(0, 39) != 0)
        d = opcode_pool[$urandom_range(0, opcode_pool.size() - 1)];
    end
  endtask

  // Input side and output back-pressure: drive on the falling edge
  int          row_idx = 0, rand_left = NumRandom, in_gap = 0;
  bit          in_took = 0, out_took = 0;
  int          out_gap = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    logic [1:0] op;
    logic [7:0] d;
    if (rst_ni && !stim_done && (!in_valid_i || in_took)) begin
      if (in_took) in_gap = gap_len();
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i = 1'b0;
      end else if (row_idx < rows.size()) begin
        op_i = rows[row_idx].op;
        read_data_i = rows[row_idx].data;
        in_valid_i = 1'b1;
      end else if (rand_left > 0) begin
        pick_item(op, d);
        op_i = op;
        read_data_i = d;
        in_valid_i = 1'b1;
      end else begin
        in_valid_i = 1'b0;
        stim_done = 1;
      end
    end
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 9) == 0) out_gap = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    access_t want, seen;
    in_took = in_valid_i && in_ready_o;
    out_took = out_valid_o && out_ready_i;
    if (in_took || out_took) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (in_took) begin
      sent++;
      if (op_i == OP_NMI) n_nmis++;
      if (op_i == OP_RESET) n_resets++;
      predict_access(op_i, read_data_i, want);
      if (row_idx < rows.size()) begin
        // Hand-typed rows must agree with the shadow core too
        if (rows[row_idx].typed && rows[row_idx].want != want)
          report("table", want, rows[row_idx].want);
        row_idx++;
      end else begin
        rand_left--;
      end
      pending_accesses.push_back(want);
    end
    if (out_took) begin
      seen = {bus_address_o, write_data_o, bus_write_o, opcode_fetch_o, halted_o,
              status_flags_o};
      got++;
      if (pending_accesses.size() == 0) report("unexpected", seen, '0);
      else begin
        want = pending_accesses.pop_front();
        if (seen != want) report("access", seen, want);
      end
    end
  end

  initial begin
    core_reset();
    // reset, vector at 0x8000, a few instructions, an NMI, a halt, then reset again
    rows.push_back(mk_typed(OP_RESET, 8'h00, {16'hFFFC, 8'h00, 1'b0, 1'b0, 1'b0, 8'h04}));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk_typed(OP_DATA, 8'h80, {16'h8000, 8'h00, 1'b0, 1'b1, 1'b0, 8'h04}));
    rows.push_back(mk(OP_DATA, 8'ha9));
    rows.push_back(mk(OP_DATA, 8'hFF));
    rows.push_back(mk(OP_DATA, 8'h69));
    rows.push_back(mk(OP_DATA, 8'h01));
    rows.push_back(mk(OP_DATA, 8'h85));
    rows.push_back(mk(OP_DATA, 8'hFF));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk(OP_NMI, 8'hFF));
    rows.push_back(mk(OP_DATA, 8'h20));
    rows.push_back(mk(OP_DATA, 8'h34));
    rows.push_back(mk(OP_DATA, 8'h12));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk(OP_DATA, 8'h00));
    rows.push_back(mk(OP_DATA, 8'h90));
    rows.push_back(mk(OP_ALT, 8'h6c));
    rows.push_back(mk(OP_DATA, 8'h02));
    rows.push_back(mk(OP_DATA, 8'hFF));
    rows.push_back(mk(OP_NMI, 8'h00));
    rows.push_back(mk_typed(OP_RESET, 8'hFF, {16'hFFFC, 8'h00, 1'b0, 1'b0, 1'b0, 8'h04}));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (!(stim_done && pending_accesses.size() == 0) && idle_cycles < WatchLimit)
      @(posedge clk_i);
    if (idle_cycles >= WatchLimit) begin
      $display("timeout: no transfer for %0d cycles", WatchLimit);
      $display("tb_cpu_6502_subset_core failed");
      $finish;
    end else begin
      repeat (20) @(posedge clk_i);
      $display("covered %0d steps in, %0d accesses out: %0d halts, %0d NMIs, %0d resets",
               sent, got, n_halts, n_nmis, n_resets);
      if (errors == 0 && pending_accesses.size() == 0) $display("tb_cpu_6502_subset_core passed");
      else $display("tb_cpu_6502_subset_core failed");
      $finish;
    end
  end

endmodule
